// ----- rtl/ftrs_pkg.sv -----
// ----------------------------------------------------------------------------
// Fenwick tree range-sum package
// Field widths, command codes and defaults shared by the block's files.
// ----------------------------------------------------------------------------
`default_nettype none

package ftrs_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned DATA_W = 32;

  localparam int unsigned DEPTH_DEFAULT = 1024;

  localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic [CMD_W-1:0] CMD_POINT_ADD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RANGE_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PREFIX_SUM = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RANGE_SUM  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/ftrs_if.sv -----
// ----------------------------------------------------------------------------
// Fenwick tree range-sum channel interfaces
// Valid/ready channels for commands, results and the size register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftrs_cmd_if;
  logic                                valid;
  logic                                ready;
  logic        [ftrs_pkg::CMD_W-1:0]   cmd;
  logic        [ftrs_pkg::IDX_W-1:0]   index_a;
  logic        [ftrs_pkg::IDX_W-1:0]   index_b;
  logic signed [ftrs_pkg::DATA_W-1:0]  value;

  modport source (output valid, cmd, index_a, index_b, value, input ready);
  modport sink (input valid, cmd, index_a, index_b, value, output ready);
endinterface

interface ftrs_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [ftrs_pkg::DATA_W-1:0]  sum;
  logic                                status;

  modport source (output valid, sum, status, input ready);
  modport sink (input valid, sum, status, output ready);
endinterface

interface ftrs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ftrs_pkg::IDX_W-1:0]  size_in_use;

  modport source (output valid, size_in_use, input ready);
  modport sink (input valid, size_in_use, output ready);
endinterface

`default_nettype wire

// ----- rtl/ftrs_ram.sv -----
// ----------------------------------------------------------------------------
// Fenwick tree range-sum RAM
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ftrs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fenwick_tree_range_sum.sv -----
// ----------------------------------------------------------------------------
// Fenwick tree range-sum block
// Binary indexed tree over a RAM of signed 32-bit words with point and range
// adds, prefix and range sums, and a clear command.
// ----------------------------------------------------------------------------
// Usage: a command transaction on req carries cmd, index_a, index_b and value.
// Every command gives exactly one result transaction on rsp (sum, status).
// The cfg channel writes size_in_use; it is always ready and is meant to be
// written while no command is in flight.
// A command walks the tree in the RAM, issuing one read per cycle; an add
// writes each node back in the cycle after its read. Every command but clear
// is done as two walks, each visiting at most about log2 of DEPTH nodes.
// The clear command sweeps the RAM one word per cycle.
// After reset the same sweep runs before req goes ready.
// Only one command is worked on at a time. The finished result sits in an
// output register, so a new command is taken while the receiver stalls; the
// block then holds its next result until that register is emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module fenwick_tree_range_sum #(
  parameter int unsigned DEPTH = ftrs_pkg::DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  ftrs_cmd_if.sink   req,
  ftrs_rsp_if.source rsp,
  ftrs_cfg_if.sink   cfg
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned IW = ftrs_pkg::IDX_W;
  localparam int unsigned DW = ftrs_pkg::DATA_W;
  localparam int unsigned W  = (AW + 1 > IW + 1) ? AW + 1 : IW + 1;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t          state;
  logic [IW-1:0]   size_reg;
  logic            err;
  logic            up;
  logic            phase;
  logic [W-1:0]    idx;
  logic [W-1:0]    idx_second;
  logic [DW-1:0]   val;
  logic [DW-1:0]   val_second;
  logic [DW-1:0]   acc;
  logic            pend_valid;
  logic [AW-1:0]   pend_addr;
  logic [AW-1:0]   clr_ctr;
  logic            clr_cmd;
  logic            out_valid;
  logic [DW-1:0]   out_sum;
  logic            out_status;

  logic [W-1:0]    lim;
  logic [W-1:0]    size_ext;
  logic [W-1:0]    depth_w;
  logic [W-1:0]    a_ext;
  logic [W-1:0]    b_ext;
  logic [W-1:0]    idx_m1;
  logic [W-1:0]    idx_low;
  logic [W-1:0]    idx_next;
  logic            idx_active;
  logic            issue;
  logic            walk_done;
  logic            accept;
  logic            out_load;

  logic            dec_err;
  logic            dec_up;
  logic            dec_clear;
  logic [W-1:0]    dec_first;
  logic [W-1:0]    dec_second;
  logic [DW-1:0]   dec_val_second;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [DW-1:0]   ram_wdata;
  logic [DW-1:0]   ram_rdata;

  assign size_ext = {{(W - IW){1'b0}}, size_reg};
  assign depth_w  = W'(DEPTH);
  assign lim      = (size_ext > depth_w) ? depth_w : size_ext;
  assign a_ext    = {{(W - IW){1'b0}}, req.index_a};
  assign b_ext    = {{(W - IW){1'b0}}, req.index_b};

  assign idx_m1     = idx - W'(1);
  assign idx_low    = idx & (~idx + W'(1));
  assign idx_next   = up ? (idx + idx_low) : (idx & idx_m1);
  assign idx_active = (idx != '0) && (!up || (idx <= lim));
  assign issue      = (state == ST_WALK) && idx_active;
  assign walk_done  = (state == ST_WALK) && !idx_active;

  assign accept   = req.valid && req.ready;
  assign out_load = (state == ST_RESULT) && (!out_valid || rsp.ready);

  assign req.ready  = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign rsp.valid  = out_valid;
  assign rsp.sum    = out_sum;
  assign rsp.status = out_status;

  always_comb begin
    dec_err        = 1'b0;
    dec_up         = 1'b0;
    dec_clear      = 1'b0;
    dec_first      = '0;
    dec_second     = '0;
    dec_val_second = '0;
    case (req.cmd)
      ftrs_pkg::CMD_POINT_ADD: begin
        dec_err   = (a_ext == '0);
        dec_up    = 1'b1;
        dec_first = a_ext;
      end
      ftrs_pkg::CMD_RANGE_ADD: begin
        dec_err        = (a_ext == '0) || (a_ext > b_ext);
        dec_up         = 1'b1;
        dec_first      = a_ext;
        dec_second     = b_ext + W'(1);
        dec_val_second = DW'(0) - DW'(req.value);
      end
      ftrs_pkg::CMD_PREFIX_SUM: begin
        dec_first = (a_ext > lim) ? lim : a_ext;
      end
      ftrs_pkg::CMD_RANGE_SUM: begin
        dec_err   = (a_ext > b_ext);
        dec_first = (b_ext > lim) ? lim : b_ext;
        if (a_ext != '0) begin
          dec_second = ((a_ext - W'(1)) > lim) ? lim : (a_ext - W'(1));
        end
      end
      ftrs_pkg::CMD_CLEAR: begin
        dec_clear = 1'b1;
      end
      default: begin
      end
    endcase
    if (dec_err) begin
      dec_first  = '0;
      dec_second = '0;
    end
  end

  assign ram_we    = (state == ST_CLEAR) || (pend_valid && up);
  assign ram_waddr = (state == ST_CLEAR) ? clr_ctr : pend_addr;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : (ram_rdata + val);

  ftrs_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (idx_m1[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      size_reg   <= ftrs_pkg::SIZE_RESET;
      clr_ctr    <= '0;
      clr_cmd    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      phase      <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        size_reg <= cfg.size_in_use;
      end
      pend_valid <= issue;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_ctr <= clr_ctr + AW'(1);
          if (clr_ctr == AW'(DEPTH - 1)) begin
            state <= clr_cmd ? ST_RESULT : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            phase <= 1'b0;
            if (dec_clear) begin
              state   <= ST_CLEAR;
              clr_ctr <= '0;
              clr_cmd <= 1'b1;
            end else begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (walk_done) begin
            if (!phase) begin
              phase <= 1'b1;
            end else begin
              state <= ST_RESULT;
            end
          end
        end
        ST_RESULT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      err        <= dec_err;
      up         <= dec_up;
      idx        <= dec_first;
      idx_second <= dec_second;
      val        <= DW'(req.value);
      val_second <= dec_val_second;
      acc        <= '0;
    end else begin
      if (issue) begin
        idx       <= idx_next;
        pend_addr <= idx_m1[AW-1:0];
      end else if (walk_done && !phase) begin
        idx <= idx_second;
        val <= val_second;
      end
      if (pend_valid && !up) begin
        acc <= phase ? (acc - ram_rdata) : (acc + ram_rdata);
      end
    end
    if (out_load) begin
      out_sum    <= acc;
      out_status <= err;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ftrs_checker.sv -----
// ----------------------------------------------------------------------------
// Fenwick tree range-sum checker
// Port-level assertions on the block's channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ftrs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [ftrs_pkg::DATA_W-1:0] rsp_sum,
  input logic                       rsp_status
);

  // A result that waits for the receiver stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_sum) && $stable(rsp_status))
    else $error("result payload changed while stalled");

  // Reset empties the output register and starts the clearing pass.
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_ready)
    else $error("block not quiet after reset");

  // A failed command reports a zero sum.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> rsp_sum == '0)
    else $error("nonzero sum with bad index status");

  // One command is worked on at a time.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command accepted while another is in flight");

endmodule

bind fenwick_tree_range_sum ftrs_checker u_ftrs_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_sum    (rsp.sum),
  .rsp_status (rsp.status)
);

`default_nettype wire
